@@ rtl/lrb_pkg.sv @@
// Shared types and constants for the link reconnect backoff block.
// No dependencies; used by lrb_core and link_reconnect_backoff_top.
package lrb_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int NOW_W          = 32;
  localparam int CFG_W          = 31;
  localparam int DROP_W         = 32;
  localparam int EVT_W          = 3;
  localparam int IDX_W          = 2;

  localparam logic [CFG_W-1:0] TIMEOUT_RST   = 31'd20000;
  localparam logic [CFG_W-1:0] RETRY_MIN_RST = 31'd1000;
  localparam logic [CFG_W-1:0] RETRY_MAX_RST = 31'd60000;

  typedef enum logic [IDX_W-1:0] {
    REG_TIMEOUT   = 2'd0,
    REG_RETRY_MIN = 2'd1,
    REG_RETRY_MAX = 2'd2
  } lrb_reg_t;

  typedef enum logic [EVT_W-1:0] {
    EV_NONE    = 3'd0,
    EV_ASSOC   = 3'd1,
    EV_REASSOC = 3'd2,
    EV_LOST    = 3'd3,
    EV_ABANDON = 3'd4
  } lrb_event_t;

  typedef struct packed {
    logic [CFG_W-1:0] connect_timeout;
    logic [CFG_W-1:0] retry_min;
    logic [CFG_W-1:0] retry_max;
  } lrb_cfg_t;

  typedef struct packed {
    logic              ready_res;
    logic              start_attempt;
    lrb_event_t        event_res;
    logic              attempting;
    logic [DROP_W-1:0] drop_total;
    logic [CFG_W-1:0]  backoff_now;
  } lrb_res_t;

endpackage

@@ rtl/lrb_core.sv @@
// Association supervisor state and per-tick next-state logic.
// Depends on lrb_pkg; state advances on each beat taken from the input register.
module lrb_core import lrb_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [NOW_W-1:0] now_ms,
  input  logic             link_up,
  input  lrb_cfg_t         cfg,
  output lrb_res_t         res
);

  logic                  is_associated, is_associated_next;
  logic                  in_attempt, in_attempt_next;
  logic                  ever_attempted, ever_attempted_next;
  logic [TIME_WIDTH-1:0] attempt_deadline, attempt_deadline_next;
  logic [TIME_WIDTH-1:0] next_try_time, next_try_time_next;
  logic [CFG_W-1:0]      retry_interval, retry_interval_next;
  logic [DROP_W-1:0]     drops, drops_next;

  logic [63:0]           now_wide, tmo_wide, ivl_wide;
  logic [TIME_WIDTH-1:0] now_t, tmo_t, ivl_t, dl_diff, try_diff;
  logic [CFG_W:0]        doubled;
  logic                  start;
  lrb_event_t            evt;

  // time taken modulo 2^TIME_WIDTH
  assign now_wide = {{(64-NOW_W){1'b0}}, now_ms};
  assign now_t    = now_wide[TIME_WIDTH-1:0];
  assign tmo_wide = {{(64-CFG_W){1'b0}}, cfg.connect_timeout};
  assign tmo_t    = tmo_wide[TIME_WIDTH-1:0];

  always_comb begin
    is_associated_next    = is_associated;
    in_attempt_next       = in_attempt;
    ever_attempted_next   = ever_attempted;
    attempt_deadline_next = attempt_deadline;
    next_try_time_next    = next_try_time;
    retry_interval_next   = retry_interval;
    drops_next            = drops;
    start                 = 1'b0;
    evt                   = EV_NONE;
    ivl_wide              = '0;
    ivl_t                 = '0;
    doubled               = '0;
    dl_diff               = now_t - attempt_deadline;
    try_diff              = '0;
    if (link_up) begin
      if (!is_associated) begin
        evt                 = in_attempt ? EV_ASSOC : EV_REASSOC;
        is_associated_next  = 1'b1;
        in_attempt_next     = 1'b0;
        retry_interval_next = cfg.retry_min;
      end
    end else begin
      if (is_associated) begin
        drops_next          = drops + 1'b1;
        is_associated_next  = 1'b0;
        next_try_time_next  = now_t;
        retry_interval_next = cfg.retry_min;
        evt                 = EV_LOST;
      end
      ivl_wide = {{(64-CFG_W){1'b0}}, retry_interval_next};
      ivl_t    = ivl_wide[TIME_WIDTH-1:0];
      doubled  = {retry_interval_next, 1'b0};
      try_diff = now_t - next_try_time_next;
      if (in_attempt) begin
        // deadline reached when wrap-safe difference is non-negative
        if (!dl_diff[TIME_WIDTH-1]) begin
          in_attempt_next     = 1'b0;
          next_try_time_next  = now_t + ivl_t;
          retry_interval_next = (doubled > {1'b0, cfg.retry_max}) ?
                                cfg.retry_max : doubled[CFG_W-1:0];
          is_associated_next  = 1'b0;
          evt                 = EV_ABANDON;
        end
      end else if (!ever_attempted || !try_diff[TIME_WIDTH-1]) begin
        ever_attempted_next   = 1'b1;
        in_attempt_next       = 1'b1;
        attempt_deadline_next = now_t + tmo_t;
        start                 = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_associated    <= 1'b0;
      in_attempt       <= 1'b0;
      ever_attempted   <= 1'b0;
      attempt_deadline <= '0;
      next_try_time    <= '0;
      retry_interval   <= RETRY_MIN_RST;
      drops            <= '0;
    end else if (advance) begin
      is_associated    <= is_associated_next;
      in_attempt       <= in_attempt_next;
      ever_attempted   <= ever_attempted_next;
      attempt_deadline <= attempt_deadline_next;
      next_try_time    <= next_try_time_next;
      retry_interval   <= retry_interval_next;
      drops            <= drops_next;
    end
  end

  always_comb begin
    res.ready_res     = link_up;
    res.start_attempt = start;
    res.event_res     = evt;
    res.attempting    = in_attempt_next;
    res.drop_total    = drops_next;
    res.backoff_now   = retry_interval_next;
  end

  // associated and attempting are never both set
  a_assoc_excl: assert property (@(posedge clk) disable iff (rst)
    !(is_associated && in_attempt))
    else $error("associated while attempt in flight");

  // a loss restarts an attempt on the same tick
  a_lost_retry: assert property (@(posedge clk) disable iff (rst)
    (advance && evt == EV_LOST) |-> start)
    else $error("loss without immediate retry");

  // a start leaves an attempt in flight and marks the block as having tried
  a_start_flag: assert property (@(posedge clk) disable iff (rst)
    (advance && start) |=> (in_attempt && ever_attempted))
    else $error("start did not register attempt");

  // an abandoned attempt leaves nothing in flight
  a_abandon: assert property (@(posedge clk) disable iff (rst)
    (advance && evt == EV_ABANDON) |=> !in_attempt)
    else $error("abandon left attempt in flight");

endmodule

@@ rtl/link_reconnect_backoff_top.sv @@
// Each input beat passes the input register, then the result register; back-pressure can hold it between.
// Throughput: one tick per cycle while out_ready holds; state update and result are one pass of lrb_core.
// Result register accepts a new beat while the previous one is being taken.
// Reset (rst, synchronous): link not associated, no attempt, drops 0, interval 1000 ms;
// registers return to timeout 20000, retry_min 1000, retry_max 60000.
// Depends on lrb_pkg and lrb_core.
module link_reconnect_backoff_top import lrb_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [NOW_W-1:0]  now_ms,
  input  logic              link_up,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              ready_res,
  output logic              start_attempt,
  output logic [EVT_W-1:0]  event_res,
  output logic              attempting,
  output logic [DROP_W-1:0] drop_total,
  output logic [CFG_W-1:0]  backoff_now,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  lrb_cfg_t         cfg;
  logic             s1_valid;
  logic [NOW_W-1:0] s1_now;
  logic             s1_up;
  logic             advance;
  lrb_res_t         res;
  lrb_res_t         out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.connect_timeout <= TIMEOUT_RST;
      cfg.retry_min       <= RETRY_MIN_RST;
      cfg.retry_max       <= RETRY_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMEOUT:   cfg.connect_timeout <= cfg_data;
        REG_RETRY_MIN: cfg.retry_min       <= cfg_data;
        REG_RETRY_MAX: cfg.retry_max       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_now <= now_ms;
      s1_up  <= link_up;
    end
  end

  lrb_core #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .now_ms  (s1_now),
    .link_up (s1_up),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign ready_res     = out_res.ready_res;
  assign start_attempt = out_res.start_attempt;
  assign event_res     = out_res.event_res;
  assign attempting    = out_res.attempting;
  assign drop_total    = out_res.drop_total;
  assign backoff_now   = out_res.backoff_now;

endmodule

@@ tb/link_reconnect_backoff_top_tb.sv @@
// Self-checking testbench for link_reconnect_backoff_top: directed table then random ticks,
// every result beat checked against an in-bench model of the reconnect supervisor.
// Depends on lrb_pkg and the RTL of link_reconnect_backoff_top.
`timescale 1ns / 1ps

module link_reconnect_backoff_top_tb;
  import lrb_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 220;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 5000;
  localparam int PRINT_CAP   = 40;

  typedef enum logic [1:0] {ROW_TICK, ROW_HAND, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [31:0]      val;
    logic             up;
    logic [IDX_W-1:0] idx;
    lrb_res_t         hand;
  } dir_row_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [NOW_W-1:0]  now_ms;
  logic              link_up;
  logic              out_valid;
  logic              out_ready;
  logic              ready_res;
  logic              start_attempt;
  logic [EVT_W-1:0]  event_res;
  logic              attempting;
  logic [DROP_W-1:0] drop_total;
  logic [CFG_W-1:0]  backoff_now;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  link_reconnect_backoff_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .now_ms        (now_ms),
    .link_up       (link_up),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ready_res     (ready_res),
    .start_attempt (start_attempt),
    .event_res     (event_res),
    .attempting    (attempting),
    .drop_total    (drop_total),
    .backoff_now   (backoff_now),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // supervisor model state and its copy of the registers
  logic              link_assoc  = 1'b0;
  logic              attempt_live = 1'b0;
  logic              tried_once  = 1'b0;
  logic [31:0]       deadline_ms = '0;
  logic [31:0]       retry_at_ms = '0;
  logic [CFG_W-1:0]  backoff_ms  = RETRY_MIN_RST;
  logic [DROP_W-1:0] drop_count  = '0;
  logic [CFG_W-1:0]  timeout_ms  = TIMEOUT_RST;
  logic [CFG_W-1:0]  min_backoff = RETRY_MIN_RST;
  logic [CFG_W-1:0]  max_backoff = RETRY_MAX_RST;

  lrb_res_t status_due[$];
  logic     hand_typed;
  lrb_res_t hand_res;

  int errors;
  int ticks_sent;
  int results_seen;
  int settings_used;
  int starts_seen;
  int abandons_seen;
  int losses_seen;
  int quiet;

  bit          no_idle;
  bit          hold_req;
  logic [31:0] sim_ms;
  logic        cur_link;

  function automatic logic time_reached(logic [31:0] t_now, logic [31:0] t_mark);
    logic [31:0] diff;
    diff = t_now - t_mark;
    return !diff[31];
  endfunction

  function automatic lrb_res_t mk_status(logic rdy, logic st, lrb_event_t ev, logic att,
                                         logic [DROP_W-1:0] drp, logic [CFG_W-1:0] bo);
    lrb_res_t r;
    r.ready_res     = rdy;
    r.start_attempt = st;
    r.event_res     = ev;
    r.attempting    = att;
    r.drop_total    = drp;
    r.backoff_now   = bo;
    return r;
  endfunction

  // one tick of the supervisor: updates model state, returns the status beat
  function automatic lrb_res_t supervise_tick(logic [31:0] t_now, logic up);
    lrb_event_t  ev;
    logic        st;
    logic [31:0] doubled;
    ev = EV_NONE;
    st = 1'b0;
    if (up) begin
      if (!link_assoc) begin
        ev = attempt_live ? EV_ASSOC : EV_REASSOC;
        link_assoc   = 1'b1;
        attempt_live = 1'b0;
        backoff_ms   = min_backoff;
      end
    end else begin
      if (link_assoc) begin
        drop_count  = drop_count + 1'b1;
        link_assoc  = 1'b0;
        retry_at_ms = t_now;
        backoff_ms  = min_backoff;
        ev = EV_LOST;
      end
      if (attempt_live) begin
        if (time_reached(t_now, deadline_ms)) begin
          doubled      = {backoff_ms, 1'b0};
          attempt_live = 1'b0;
          retry_at_ms  = t_now + backoff_ms;
          if (doubled > {1'b0, max_backoff}) doubled = {1'b0, max_backoff};
          backoff_ms = doubled[CFG_W-1:0];
          ev = EV_ABANDON;
        end
      end else if (!tried_once || time_reached(t_now, retry_at_ms)) begin
        tried_once   = 1'b1;
        attempt_live = 1'b1;
        deadline_ms  = t_now + timeout_ms;
        st = 1'b1;
      end
    end
    return mk_status(up, st, ev, attempt_live, drop_count, backoff_ms);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("MISMATCH beat %0d %s: got 0x%0h, expected 0x%0h", results_seen, what, got,
               want);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin : scoreboard
    lrb_res_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (status_due.size() == 0) begin
          errors++;
          if (errors <= PRINT_CAP) $display("UNEXPECTED status beat %0d", results_seen);
        end else begin
          want = status_due.pop_front();
          if (ready_res !== want.ready_res)
            report_mismatch("ready_res", ready_res, want.ready_res);
          if (start_attempt !== want.start_attempt)
            report_mismatch("start_attempt", start_attempt, want.start_attempt);
          if (event_res !== want.event_res)
            report_mismatch("event_res", event_res, want.event_res);
          if (attempting !== want.attempting)
            report_mismatch("attempting", attempting, want.attempting);
          if (drop_total !== want.drop_total)
            report_mismatch("drop_total", drop_total, want.drop_total);
          if (backoff_now !== want.backoff_now)
            report_mismatch("backoff_now", backoff_now, want.backoff_now);
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        want = supervise_tick(now_ms, link_up);
        // hand-typed rows override the model, the model still steps its state
        if (hand_typed) want = hand_res;
        if (want.start_attempt) starts_seen++;
        if (want.event_res == EV_ABANDON) abandons_seen++;
        if (want.event_res == EV_LOST) losses_seen++;
        status_due.push_back(want);
        ticks_sent++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == IDLE_LIMIT) begin
        $display("Timeout: no beat for %0d cycles, %0d status beats pending", IDLE_LIMIT,
                 status_due.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // result side: random back-pressure, one long hold-off on request
  initial begin : receiver
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_tick(input logic [31:0] t, input logic up, input logic typed,
                           input lrb_res_t hand);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    now_ms     <= t;
    link_up    <= up;
    hand_typed <= typed;
    hand_res   <= hand;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering, let the scoreboard queue the last beat taken, then wait for every
  // outstanding status beat and let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TIMEOUT:   timeout_ms  = val;
      REG_RETRY_MIN: min_backoff = val;
      REG_RETRY_MAX: max_backoff = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [CFG_W-1:0] tmo, input logic [CFG_W-1:0] mn,
                                input logic [CFG_W-1:0] mx);
    settle();
    cfg_write(REG_TIMEOUT, tmo);
    cfg_write(REG_RETRY_MIN, mn);
    cfg_write(REG_RETRY_MAX, mx);
    settings_used++;
  endtask

  task automatic random_phase(input int n, input logic [31:0] step_max, input int flip_pct,
                              input int hold_at, input int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) settle();
      // mostly a running clock, now and then an arbitrary jump
      if ($urandom_range(0, 99) < 4) sim_ms = $urandom();
      else sim_ms = sim_ms + $urandom_range(0, step_max);
      if ($urandom_range(0, 99) < flip_pct) cur_link = ~cur_link;
      send_tick(sim_ms, cur_link, 1'b0, '0);
    end
  endtask

  function automatic dir_row_t tick_row(logic [31:0] t, logic up);
    dir_row_t r;
    r.kind = ROW_TICK;
    r.val  = t;
    r.up   = up;
    r.idx  = REG_TIMEOUT;
    r.hand = '0;
    return r;
  endfunction

  function automatic dir_row_t hand_row(logic [31:0] t, logic up, lrb_res_t h);
    dir_row_t r;
    r = tick_row(t, up);
    r.kind = ROW_HAND;
    r.hand = h;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [IDX_W-1:0] idx, logic [31:0] val);
    dir_row_t r;
    r = tick_row(val, 1'b0);
    r.kind = ROW_CFG;
    r.idx  = idx;
    return r;
  endfunction

  initial begin : stimulus
    dir_row_t rows[$];
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    now_ms     <= '0;
    link_up    <= 1'b0;
    hand_typed <= 1'b0;
    hand_res   <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_TIMEOUT;
    cfg_data   <= '0;
    no_idle  = 1'b0;
    hold_req = 1'b0;
    sim_ms   = '0;
    cur_link = 1'b0;

    // power-on settings: first tick starts an attempt, then associate, lose, time out
    rows.push_back(hand_row(32'd0, 1'b0,
                            mk_status(1'b0, 1'b1, EV_NONE, 1'b1, 32'd0, 31'd1000)));
    rows.push_back(hand_row(32'd100, 1'b1,
                            mk_status(1'b1, 1'b0, EV_ASSOC, 1'b0, 32'd0, 31'd1000)));
    rows.push_back(hand_row(32'd200, 1'b0,
                            mk_status(1'b0, 1'b1, EV_LOST, 1'b1, 32'd1, 31'd1000)));
    rows.push_back(hand_row(32'd20199, 1'b0,
                            mk_status(1'b0, 1'b0, EV_NONE, 1'b1, 32'd1, 31'd1000)));
    rows.push_back(hand_row(32'd20200, 1'b0,
                            mk_status(1'b0, 1'b0, EV_ABANDON, 1'b0, 32'd1, 31'd2000)));
    rows.push_back(tick_row(32'd21199, 1'b0));
    rows.push_back(tick_row(32'd21200, 1'b0));
    rows.push_back(tick_row(32'd41200, 1'b0));
    rows.push_back(hand_row(32'd50000, 1'b1,
                            mk_status(1'b1, 1'b0, EV_REASSOC, 1'b0, 32'd1, 31'd1000)));
    rows.push_back(tick_row(32'd50001, 1'b1));
    // deadline across the 32-bit wrap
    rows.push_back(hand_row(32'hFFFF_FF00, 1'b0,
                            mk_status(1'b0, 1'b1, EV_LOST, 1'b1, 32'd2, 31'd1000)));
    rows.push_back(hand_row(32'hFFFF_FFFF, 1'b0,
                            mk_status(1'b0, 1'b0, EV_NONE, 1'b1, 32'd2, 31'd1000)));
    rows.push_back(hand_row(32'h0000_4D20, 1'b0,
                            mk_status(1'b0, 1'b0, EV_ABANDON, 1'b0, 32'd2, 31'd2000)));
    rows.push_back(tick_row(32'h8000_0000, 1'b0));
    // zero timeout and zero interval
    rows.push_back(cfg_row(REG_TIMEOUT, 32'd0));
    rows.push_back(cfg_row(REG_RETRY_MIN, 32'd0));
    rows.push_back(tick_row(32'd100, 1'b1));
    rows.push_back(tick_row(32'd101, 1'b0));
    rows.push_back(tick_row(32'd101, 1'b0));
    rows.push_back(tick_row(32'd101, 1'b0));
    // ceiling below the initial interval
    rows.push_back(cfg_row(REG_TIMEOUT, 32'd10));
    rows.push_back(cfg_row(REG_RETRY_MIN, 32'd5000));
    rows.push_back(cfg_row(REG_RETRY_MAX, 32'd3000));
    rows.push_back(tick_row(32'd200, 1'b1));
    rows.push_back(tick_row(32'd201, 1'b0));
    rows.push_back(tick_row(32'd211, 1'b0));
    // all-ones registers: doubling overflows 31 bits before the clamp
    rows.push_back(cfg_row(REG_TIMEOUT, 32'h7FFF_FFFF));
    rows.push_back(cfg_row(REG_RETRY_MIN, 32'h7FFF_FFFF));
    rows.push_back(cfg_row(REG_RETRY_MAX, 32'h7FFF_FFFF));
    rows.push_back(cfg_row(REG_UNUSED, 32'h0000_1234));
    rows.push_back(tick_row(32'd300, 1'b1));
    rows.push_back(tick_row(32'd301, 1'b0));
    rows.push_back(tick_row(32'h8000_012C, 1'b0));
    rows.push_back(tick_row(32'h0000_012A, 1'b0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    settings_used = 1;
    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_CFG: begin
          settle();
          cfg_write(rows[i].idx, rows[i].val[CFG_W-1:0]);
        end
        ROW_HAND: send_tick(rows[i].val, rows[i].up, 1'b1, rows[i].hand);
        default:  send_tick(rows[i].val, rows[i].up, 1'b0, '0);
      endcase
    end
    settings_used += 3;

    apply_settings(TIMEOUT_RST, RETRY_MIN_RST, RETRY_MAX_RST);
    random_phase(PHASE_ITEMS, 32'd3000, 5, -1, -1);

    // short timers so deadlines and retries come round often
    for (int p = 0; p < 4; p++) begin
      no_idle = (p == 1);
      apply_settings(CFG_W'($urandom_range(0, 60)), CFG_W'($urandom_range(0, 16)),
                     CFG_W'($urandom_range(0, 300)));
      random_phase(PHASE_ITEMS, 32'd40, 8, (p == 1) ? 50 : -1, (p == 2) ? 100 : -1);
    end
    no_idle = 1'b0;

    apply_settings('0, '0, CFG_W'($urandom_range(0, 300)));
    random_phase(PHASE_ITEMS, 32'd3, 10, -1, -1);

    apply_settings(31'd20, CFG_W'($urandom_range(50, 200)), CFG_W'($urandom_range(1, 49)));
    random_phase(PHASE_ITEMS, 32'd30, 8, -1, -1);

    apply_settings(CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom()));
    cfg_write(REG_UNUSED, CFG_W'($urandom()));
    random_phase(PHASE_ITEMS, 32'hFFFF_FFFF, 10, -1, -1);

    apply_settings(31'h7FFF_FFFF, 31'h4000_0000, 31'h7FFF_FFFF);
    random_phase(PHASE_ITEMS, 32'hFFFF_FFFF, 10, -1, -1);

    settle();
    $display("Covered %0d ticks under %0d register settings, incl. wrap, zero and clamp cases.",
             ticks_sent, settings_used);
    $display("Checked %0d status beats: %0d starts, %0d abandons, %0d losses, %0d mismatches.",
             results_seen, starts_seen, abandons_seen, losses_seen, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
